// ===== src/linear_scan_priority_queue_macros.svh =====
// assertion macros used by the rtl controller
`ifndef LINEAR_SCAN_PRIORITY_QUEUE_MACROS_SVH
`define LINEAR_SCAN_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTH
`define LSPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lspq assertion failed");
`define LSPQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lspq assertion failed");
`else
`define LSPQ_ASSERT_NOW(label, ante, cons)
`define LSPQ_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== src/lspq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lspq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int PRIO_W    = 8;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage
`default_nettype wire

// ===== src/lspq_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lspq_mem
  import lspq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire mem_ctl_t                 ctl,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire entry_t                   wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output entry_t                        rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== src/lspq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "linear_scan_priority_queue_macros.svh"
module lspq_ctrl
  import lspq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     in_mode,
  input  wire logic [PRIO_W-1:0]        in_priority_req,
  input  wire logic signed [DATA_W-1:0] in_payload,
  output logic                          out_valid,
  output logic [STATUS_W-1:0]           out_status,
  output logic [PRIO_W-1:0]             out_priority,
  output logic signed [DATA_W-1:0]      out_payload,
  output mem_ctl_t                      mem_ctl,
  output logic [$clog2(DEPTH)-1:0]      mem_waddr,
  output entry_t                        mem_wdata,
  output logic [$clog2(DEPTH)-1:0]      mem_raddr,
  input  wire entry_t                   mem_rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MOVE = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       rd_idx_r, rd_idx_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [CW-1:0]       chk_idx_r, chk_idx_nxt;
  logic [AW-1:0]       best_idx_r, best_idx_nxt;
  entry_t              best_r, best_nxt;
  entry_t              last_r, last_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [PRIO_W-1:0]   out_prio_r, out_prio_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    best_idx_nxt   = best_idx_r;
    best_nxt       = best_r;
    last_nxt       = last_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_prio_nxt   = out_prio_r;
    out_data_nxt   = out_data_r;
    mem_ctl        = '0;
    mem_waddr      = count_r[AW-1:0];
    mem_wdata      = '{prio: in_priority_req, data: in_payload};
    mem_raddr      = rd_idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_prio_nxt = '0;
          out_data_nxt = '0;
          if (in_mode == MODE_INSERT) begin
            out_valid_nxt = 1'b1;
            if (count_r == CW'(DEPTH)) begin
              out_status_nxt = STATUS_FULL;
            end else begin
              out_status_nxt = STATUS_OK;
              mem_ctl.wr_en  = 1'b1;
              count_nxt      = CW'(count_r + 1'b1);
            end
          end else if (count_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_EMPTY;
          end else begin
            state_nxt  = S_SCAN;
            rd_idx_nxt = '0;
          end
        end
      end
      S_SCAN: begin
        if (rd_idx_r < count_r) begin
          mem_ctl.rd_en = 1'b1;
          rd_idx_nxt    = CW'(rd_idx_r + 1'b1);
          chk_vld_nxt   = 1'b1;
          chk_idx_nxt   = rd_idx_r;
        end
        if (chk_vld_r) begin
          // strict compare keeps the lowest slot on a tie
          if (chk_idx_r == '0 || mem_rdata.prio > best_r.prio) begin
            best_nxt     = mem_rdata;
            best_idx_nxt = chk_idx_r[AW-1:0];
          end
          if (chk_idx_r == CW'(count_r - 1'b1)) begin
            last_nxt  = mem_rdata;
            state_nxt = S_MOVE;
          end
        end
      end
      S_MOVE: begin
        // last entry fills the freed slot
        mem_ctl.wr_en  = 1'b1;
        mem_waddr      = best_idx_r;
        mem_wdata      = last_r;
        count_nxt      = CW'(count_r - 1'b1);
        out_valid_nxt  = 1'b1;
        out_status_nxt = STATUS_OK;
        out_prio_nxt   = best_r.prio;
        out_data_nxt   = best_r.data;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r    <= chk_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_r       <= best_nxt;
    last_r       <= last_nxt;
    out_status_r <= out_status_nxt;
    out_prio_r   <= out_prio_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_priority = out_prio_r;
  assign out_payload  = out_data_r;

  `LSPQ_ASSERT_NOW(a_count_max, 1'b1, count_r <= CW'(DEPTH))
  `LSPQ_ASSERT_NXT(a_move_dec, state_r == S_MOVE, count_r == CW'($past(count_r) - 1'b1))
  `LSPQ_ASSERT_NOW(a_strobe_idle, out_valid_r, state_r == S_IDLE)
  `LSPQ_ASSERT_NOW(a_move_slot, state_r == S_MOVE, CW'(best_idx_r) < count_r)
  `LSPQ_ASSERT_NOW(a_scan_nonempty, state_r == S_SCAN, count_r != '0)

endmodule
`default_nettype wire

// ===== src/linear_scan_priority_queue.sv =====
// insert and remove on an empty queue: result strobe in the cycle after the transfer,
//   next transfer taken on the following edge
// remove: result strobe after the one-entry-per-cycle read port scan of all stored entries
//   plus the write-back of the last entry into the freed slot
// rst_n is synchronous and active low; it empties the queue, stores stay undefined
// the receiver cannot stall: out_valid is high for exactly one cycle per result
`timescale 1ns / 1ps
`default_nettype none
module linear_scan_priority_queue
  import lspq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     in_mode,
  input  wire logic [PRIO_W-1:0]        in_priority_req,
  input  wire logic signed [DATA_W-1:0] in_payload,
  output logic                          out_valid,
  output logic [STATUS_W-1:0]           out_status,
  output logic [PRIO_W-1:0]             out_priority,
  output logic signed [DATA_W-1:0]      out_payload
);

  localparam int AW = $clog2(DEPTH);

  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;

  lspq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_priority_req(in_priority_req),
    .in_payload     (in_payload),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_priority   (out_priority),
    .out_payload    (out_payload),
    .mem_ctl        (mem_ctl),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  lspq_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk  (clk),
    .ctl  (mem_ctl),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule
`default_nettype wire

// ===== sim/lspq_result_check.sv =====
`timescale 1ns / 1ps
module lspq_result_check
  import lspq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic                     busy,
  input  wire logic                     in_mode,
  input  wire logic [PRIO_W-1:0]        in_priority_req,
  input  wire logic signed [DATA_W-1:0] in_payload,
  input  wire logic                     out_valid,
  input  wire logic [STATUS_W-1:0]      out_status,
  input  wire logic [PRIO_W-1:0]        out_priority,
  input  wire logic signed [DATA_W-1:0] out_payload,
  output int                            fail_count,
  output int                            pending,
  output int                            served_count,
  output int                            full_count,
  output int                            empty_count
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PRIO_W-1:0]   prio;
    logic [DATA_W-1:0]   data;
  } answer_t;

  logic [PRIO_W-1:0] shadow_prio [DEPTH];
  logic [DATA_W-1:0] shadow_data [DEPTH];
  int                shadow_count;
  answer_t           answers_due [$];

  function automatic answer_t apply_request(input logic mode, input logic [PRIO_W-1:0] prio,
                                            input logic [DATA_W-1:0] data);
    answer_t ans;
    int      best;
    int      last;
    ans = '0;
    if (mode == MODE_INSERT) begin
      if (shadow_count >= DEPTH) begin
        ans.status = STATUS_FULL;
      end else begin
        shadow_prio[shadow_count] = prio;
        shadow_data[shadow_count] = data;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      ans.status = STATUS_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < shadow_count; i++) begin
        if (shadow_prio[i] > shadow_prio[best]) best = i;
      end
      ans.status = STATUS_OK;
      ans.prio   = shadow_prio[best];
      ans.data   = shadow_data[best];
      last = shadow_count - 1;
      shadow_prio[best] = shadow_prio[last];
      shadow_data[best] = shadow_data[last];
      shadow_count = last;
    end
    return ans;
  endfunction

  task automatic report(input string what, input logic [DATA_W-1:0] got,
                        input logic [DATA_W-1:0] want);
    if (fail_count < 100) begin
      $display("%0t %s: got %h, expected %h", $time, what, got, want);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    answer_t ans;
    answer_t want;
    if (!rst_n) begin
      shadow_count = 0;
      answers_due.delete();
      fail_count   = 0;
      pending      = 0;
      served_count = 0;
      full_count   = 0;
      empty_count  = 0;
    end else begin
      if (start && !busy) begin
        ans = apply_request(in_mode, in_priority_req, in_payload);
        if (ans.status == STATUS_FULL) full_count++;
        else if (ans.status == STATUS_EMPTY) empty_count++;
        else if (in_mode == MODE_REMOVE) served_count++;
        answers_due.push_back(ans);
      end
      if (out_valid) begin
        if (answers_due.size() == 0) begin
          report("result with no transfer behind it", {30'd0, out_status}, '0);
        end else begin
          want = answers_due.pop_front();
          if (out_status !== want.status) report("status", {30'd0, out_status},
                                                 {30'd0, want.status});
          if (out_priority !== want.prio) report("priority", {24'd0, out_priority},
                                                 {24'd0, want.prio});
          if (out_payload !== want.data) report("payload", out_payload, want.data);
        end
      end
      pending = answers_due.size();
    end
  end

endmodule

// ===== sim/tb_linear_scan_priority_queue.sv =====
`timescale 1ns / 1ps
module tb_linear_scan_priority_queue;
  import lspq_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1080;
  localparam int CALM_TAIL    = 150;
  // slot 15 down to slot 0: unique maximum last, ties at 200 and 0
  localparam logic [16*PRIO_W-1:0] FILL_PRIO = {
    8'd255, 8'd0, 8'd170, 8'd85, 8'd3, 8'd200, 8'd64, 8'd254,
    8'd1, 8'd128, 8'd127, 8'd0, 8'd200, 8'd17, 8'd200, 8'd0};

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     in_mode = MODE_INSERT;
  logic [PRIO_W-1:0]        in_priority_req = '0;
  logic signed [DATA_W-1:0] in_payload = '0;
  logic                     out_valid;
  logic [STATUS_W-1:0]      out_status;
  logic [PRIO_W-1:0]        out_priority;
  logic signed [DATA_W-1:0] out_payload;

  int fail_count;
  int pending;
  int served_count;
  int full_count;
  int empty_count;
  int transfers = 0;
  int cycles = 0;

  linear_scan_priority_queue dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_priority_req (in_priority_req),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_priority    (out_priority),
    .out_payload     (out_payload)
  );

  lspq_result_check check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_priority_req (in_priority_req),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_priority    (out_priority),
    .out_payload     (out_payload),
    .fail_count      (fail_count),
    .pending         (pending),
    .served_count    (served_count),
    .full_count      (full_count),
    .empty_count     (empty_count)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("linear_scan_priority_queue: mismatch");
      $finish;
    end
  end

  task automatic send(input logic mode, input logic [PRIO_W-1:0] prio,
                      input logic [DATA_W-1:0] data);
    start           <= 1'b1;
    in_mode         <= mode;
    in_priority_req <= prio;
    in_payload      <= data;
    do @(posedge clk); while (busy);
    transfers++;
  endtask

  // start low, junk on the fields
  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) begin
      in_mode         <= 1'($urandom_range(0, 1));
      in_priority_req <= PRIO_W'($urandom);
      in_payload      <= $urandom;
      @(posedge clk);
    end
  endtask

  initial begin
    logic              mode;
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
    int                ins_pct;
    int                idle_pct;
    ins_pct  = 50;
    idle_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send(MODE_REMOVE, 8'hff, 32'hffff_ffff);
    for (int i = 0; i < 16; i++) begin
      case (i)
        0:       data = 32'h8000_0000;
        1:       data = 32'h7fff_ffff;
        2:       data = 32'h0000_0000;
        3:       data = 32'hffff_ffff;
        default: data = $urandom;
      endcase
      send(MODE_INSERT, FILL_PRIO[i*PRIO_W +: PRIO_W], data);
    end
    send(MODE_INSERT, 8'hff, 32'h1234_5678);
    repeat (4) send(MODE_REMOVE, 8'h00, 32'h0000_0000);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 90 == 0) begin
        case ($urandom_range(0, 4))
          0:       ins_pct = 85;
          1:       ins_pct = 15;
          2:       ins_pct = 50;
          3:       ins_pct = 65;
          default: ins_pct = 35;
        endcase
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 25;
          default: idle_pct = 60;
        endcase
      end
      mode = ($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_REMOVE;
      case ($urandom_range(0, 7))
        0:       prio = 8'd0;
        1:       prio = 8'd255;
        2, 3:    prio = PRIO_W'($urandom);
        default: prio = PRIO_W'($urandom_range(100, 103));
      endcase
      case ($urandom_range(0, 9))
        0:       data = 32'h8000_0000;
        1:       data = 32'h7fff_ffff;
        default: data = $urandom;
      endcase
      send(mode, prio, data);
      if (n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 99) < idle_pct) begin
        pause($urandom_range(1, 9));
      end
    end

    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (25) @(posedge clk);
    @(negedge clk);
    $display("%0d transfers in: %0d entries served, %0d refused as full, %0d as empty",
             transfers, served_count, full_count, empty_count);
    if (fail_count == 0 && pending == 0) begin
      $display("linear_scan_priority_queue: match");
    end else begin
      $display("linear_scan_priority_queue: mismatch");
    end
    $finish;
  end

endmodule
